[rtl/bce_pkg.sv]
// ----------------------------------------------------------------------------
// bce_pkg: shared types, constants and microcode for the bech32 encoder.
// Holds the item structs, the polymod step, the charset and the control ROM.
// ----------------------------------------------------------------------------
package bce_pkg;

    // Default prefix capacity of the low-part store.
    localparam int MAX_PREFIX_DEF = 64;

    // Request and result payloads.
    typedef struct packed {
        logic [1:0] op;
        logic [6:0] prefix_char;
        logic [4:0] data_symbol;
    } in_item_t;

    typedef struct packed {
        logic [6:0] out_char;
        logic       last;
        logic       error;
    } out_item_t;

    // Request operation codes.
    localparam logic [1:0] OP_PREFIX = 2'd0;
    localparam logic [1:0] OP_DATA   = 2'd1;
    localparam logic [1:0] OP_FINISH = 2'd2;

    // Separator and error characters.
    localparam logic [6:0] SEP_CHAR  = 7'h31;
    localparam logic [6:0] NULL_CHAR = 7'h00;

    // Polymod generator and accumulator constants.
    localparam logic [29:0] GEN0      = 30'h3b6a57b2;
    localparam logic [29:0] GEN1      = 30'h26508e6d;
    localparam logic [29:0] GEN2      = 30'h1ea119fa;
    localparam logic [29:0] GEN3      = 30'h3d4233dd;
    localparam logic [29:0] GEN4      = 30'h2a1462b3;
    localparam logic [29:0] ACC_RESET = 30'd1;
    localparam logic [29:0] FINAL_XOR = 30'd1;

    // The 32-letter charset, first letter in the top byte.
    localparam logic [255:0] CHARSET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";

    // Loop counts of the finish routine, as the last counter value.
    localparam int FOLD_LAST = 4;
    localparam int CHK_LAST  = 5;

    // Microcode fields.
    typedef enum logic [2:0] {
        F_NONE, F_ZERO, F_PCHI, F_DSYM, F_MEM
    } fold_src_t;

    typedef enum logic [2:0] {
        E_NONE, E_ECHO, E_ERROR, E_SEP, E_LETTER, E_CHECK
    } emit_t;

    typedef enum logic [2:0] {
        J_NEXT, J_ALWAYS, J_DISPATCH, J_WALK_MORE, J_PFX_EMPTY,
        J_OP_FINISH, J_FOLD_MORE, J_CHK_MORE
    } jump_t;

    localparam int PC_W = 4;
    typedef logic [PC_W-1:0] pc_t;

    // Microprogram entry points and steps.
    localparam pc_t A_IDLE  = 4'd0;
    localparam pc_t A_PFX   = 4'd1;
    localparam pc_t A_ERR   = 4'd2;
    localparam pc_t A_CLOSE = 4'd3;
    localparam pc_t A_WALK  = 4'd4;
    localparam pc_t A_SEP   = 4'd5;
    localparam pc_t A_DATA  = 4'd6;
    localparam pc_t A_FIN   = 4'd7;
    localparam pc_t A_FOLD  = 4'd8;
    localparam pc_t A_PREP  = 4'd9;
    localparam pc_t A_CHECK = 4'd10;
    localparam pc_t A_CLEAR = 4'd11;

    typedef struct packed {
        fold_src_t fold_src;
        emit_t     emit;
        logic      store_wr;
        logic      walk_clr;
        logic      walk_inc;
        logic      set_dp;
        logic      clr_state;
        jump_t     jump;
        pc_t       target;
    } ctrl_t;

    // Datapath conditions seen by the sequencer.
    typedef struct packed {
        logic data_phase;
        logic pfx_full;
        logic pfx_empty;
        logic walk_more;
        logic fold_more;
        logic chk_more;
        logic op_finish;
    } status_t;

    // One polymod step: shift in a five-bit symbol and reduce.
    function automatic logic [29:0] fold(logic [29:0] acc, logic [4:0] sym);
        logic [4:0]  top;
        logic [29:0] r;
        begin
            top = acc[29:25];
            r   = {acc[24:0], sym};
            if (top[0]) r = r ^ GEN0;
            if (top[1]) r = r ^ GEN1;
            if (top[2]) r = r ^ GEN2;
            if (top[3]) r = r ^ GEN3;
            if (top[4]) r = r ^ GEN4;
            return r;
        end
    endfunction

    // Charset lookup of a five-bit value.
    function automatic logic [6:0] letter(logic [4:0] idx);
        logic [7:0] ch;
        begin
            ch = CHARSET[8 * (31 - int'(idx)) +: 8];
            return ch[6:0];
        end
    endfunction

    // Control ROM: one word per microprogram step.
    function automatic ctrl_t rom_word(pc_t pc);
        ctrl_t w;
        begin
            w          = '0;
            w.fold_src = F_NONE;
            w.emit     = E_NONE;
            w.jump     = J_NEXT;
            w.target   = A_IDLE;
            case (pc)
                A_IDLE:
                begin
                    w.jump = J_DISPATCH;
                end
                A_PFX:
                begin
                    w.fold_src = F_PCHI;
                    w.store_wr = 1'b1;
                    w.emit     = E_ECHO;
                    w.jump     = J_ALWAYS;
                    w.target   = A_IDLE;
                end
                A_ERR:
                begin
                    w.emit   = E_ERROR;
                    w.jump   = J_ALWAYS;
                    w.target = A_IDLE;
                end
                A_CLOSE:
                begin
                    w.fold_src = F_ZERO;
                    w.walk_clr = 1'b1;
                    w.jump     = J_PFX_EMPTY;
                    w.target   = A_SEP;
                end
                A_WALK:
                begin
                    w.fold_src = F_MEM;
                    w.walk_inc = 1'b1;
                    w.jump     = J_WALK_MORE;
                    w.target   = A_WALK;
                end
                A_SEP:
                begin
                    w.emit   = E_SEP;
                    w.set_dp = 1'b1;
                    w.jump   = J_OP_FINISH;
                    w.target = A_FIN;
                end
                A_DATA:
                begin
                    w.fold_src = F_DSYM;
                    w.emit     = E_LETTER;
                    w.jump     = J_ALWAYS;
                    w.target   = A_IDLE;
                end
                A_FIN:
                begin
                    w.fold_src = F_ZERO;
                    w.walk_clr = 1'b1;
                end
                A_FOLD:
                begin
                    w.fold_src = F_ZERO;
                    w.walk_inc = 1'b1;
                    w.jump     = J_FOLD_MORE;
                    w.target   = A_FOLD;
                end
                A_PREP:
                begin
                    w.walk_clr = 1'b1;
                end
                A_CHECK:
                begin
                    w.emit     = E_CHECK;
                    w.walk_inc = 1'b1;
                    w.jump     = J_CHK_MORE;
                    w.target   = A_CHECK;
                end
                A_CLEAR:
                begin
                    w.clr_state = 1'b1;
                    w.jump      = J_ALWAYS;
                    w.target    = A_IDLE;
                end
                default:
                begin
                    w.jump   = J_ALWAYS;
                    w.target = A_IDLE;
                end
            endcase
            return w;
        end
    endfunction

endpackage

[rtl/bce_seq.sv]
// ----------------------------------------------------------------------------
// bce_seq: microcode sequencer.
// Steps through the control ROM, dispatches new requests and takes jumps.
// ----------------------------------------------------------------------------
module bce_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sym_valid,
    input  logic [1:0]        sym_op,
    input  bce_pkg::status_t  status,
    input  logic              out_free,
    output bce_pkg::ctrl_t    ctrl,
    output logic              go,
    output logic              at_idle
);
    import bce_pkg::*;

    pc_t pc_reg;
    pc_t pc_next;
    pc_t entry;
    logic taken;

    // The current control word comes straight from the ROM.
    assign ctrl    = rom_word(pc_reg);
    assign at_idle = (pc_reg == A_IDLE);

    // A step waits for a request at idle, and for a free output slot if it emits.
    always_comb
    begin
        if (at_idle)
            go = sym_valid;
        else
            go = !((ctrl.emit != E_NONE) && !out_free);
    end

    // Entry point of the routine for a new request.
    always_comb
    begin
        case (sym_op)
            OP_PREFIX:
                entry = (status.data_phase || status.pfx_full) ? A_ERR : A_PFX;
            OP_DATA:
                entry = status.data_phase ? A_DATA : A_CLOSE;
            OP_FINISH:
                entry = status.data_phase ? A_FIN : A_CLOSE;
            default:
                entry = A_ERR;
        endcase
    end

    // Jump condition of the current word.
    always_comb
    begin
        case (ctrl.jump)
            J_NEXT:      taken = 1'b0;
            J_ALWAYS:    taken = 1'b1;
            J_WALK_MORE: taken = status.walk_more;
            J_PFX_EMPTY: taken = status.pfx_empty;
            J_OP_FINISH: taken = status.op_finish;
            J_FOLD_MORE: taken = status.fold_more;
            J_CHK_MORE:  taken = status.chk_more;
            default:     taken = 1'b0;
        endcase
    end

    // Next step.
    always_comb
    begin
        pc_next = pc_reg;
        if (go)
        begin
            if (ctrl.jump == J_DISPATCH)
                pc_next = entry;
            else if (taken)
                pc_next = ctrl.target;
            else
                pc_next = pc_reg + 1'b1;
        end
    end

    // Step counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= A_IDLE;
        else
            pc_reg <= pc_next;
    end

endmodule

[rtl/bce_dp.sv]
// ----------------------------------------------------------------------------
// bce_dp: encoder datapath.
// Polymod accumulator, prefix low-part memory, counters and output register.
// ----------------------------------------------------------------------------
module bce_dp #(
    parameter int MAX_PREFIX = bce_pkg::MAX_PREFIX_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  bce_pkg::ctrl_t      ctrl,
    input  logic                go,
    input  logic                accept,
    input  bce_pkg::in_item_t   item,
    input  logic                chr_stall,
    output bce_pkg::status_t    status,
    output logic                out_free,
    output logic                chr_valid,
    output bce_pkg::out_item_t  chr_data
);
    import bce_pkg::*;

    localparam int CNT_W  = $clog2(MAX_PREFIX + 1);
    localparam int ADDR_W = (MAX_PREFIX > 1) ? $clog2(MAX_PREFIX) : 1;
    localparam int WALK_W = (CNT_W > 3) ? CNT_W : 3;

    in_item_t          item_reg;
    logic [29:0]       acc_reg;
    logic [29:0]       acc_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              dp_reg;
    logic              dp_next;
    logic [WALK_W-1:0] walk_reg;
    logic [WALK_W-1:0] walk_next;
    logic [4:0]        rd_data_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic [4:0]        fold_sym;
    logic [29:0]       mod;
    logic [4:0]        group;
    logic              out_valid_reg;
    logic              out_valid_next;
    out_item_t         out_reg;
    out_item_t         out_next;
    logic              emit_go;

    logic [4:0] low_part_mem [MAX_PREFIX];

    assign emit_go = go && (ctrl.emit != E_NONE);

    // Conditions for the sequencer.
    always_comb
    begin
        status.data_phase = dp_reg;
        status.pfx_full   = (count_reg == CNT_W'(MAX_PREFIX));
        status.pfx_empty  = (count_reg == '0);
        status.walk_more  = ((WALK_W + 1)'(walk_reg) + 1'b1) < (WALK_W + 1)'(count_reg);
        status.fold_more  = (walk_reg != WALK_W'(FOLD_LAST));
        status.chk_more   = (walk_reg != WALK_W'(CHK_LAST));
        status.op_finish  = (item_reg.op == OP_FINISH);
    end

    // Walk counter, also used as loop counter in the finish routine.
    always_comb
    begin
        walk_next = walk_reg;
        if (go && ctrl.walk_clr)
            walk_next = '0;
        else if (go && ctrl.walk_inc)
            walk_next = walk_reg + 1'b1;
    end

    // Read one ahead, so the registered data matches the walk counter.
    assign rd_addr = (walk_next < WALK_W'(MAX_PREFIX)) ? walk_next[ADDR_W-1:0] : '0;

    // Symbol folded into the polymod this step.
    always_comb
    begin
        case (ctrl.fold_src)
            F_ZERO:  fold_sym = 5'd0;
            F_PCHI:  fold_sym = {3'b000, item_reg.prefix_char[6:5]};
            F_DSYM:  fold_sym = item_reg.data_symbol;
            F_MEM:   fold_sym = rd_data_reg;
            default: fold_sym = 5'd0;
        endcase
    end

    // Accumulator, prefix count and phase flag.
    always_comb
    begin
        acc_next   = acc_reg;
        count_next = count_reg;
        dp_next    = dp_reg;
        if (go && ctrl.clr_state)
        begin
            acc_next   = ACC_RESET;
            count_next = '0;
            dp_next    = 1'b0;
        end
        else if (go)
        begin
            if (ctrl.fold_src != F_NONE)
                acc_next = fold(acc_reg, fold_sym);
            if (ctrl.store_wr)
                count_next = count_reg + 1'b1;
            if (ctrl.set_dp)
                dp_next = 1'b1;
        end
    end

    // Checksum group picked by the loop counter, most significant first.
    assign mod = acc_reg ^ FINAL_XOR;

    always_comb
    begin
        case (walk_reg[2:0])
            3'd0:    group = mod[29:25];
            3'd1:    group = mod[24:20];
            3'd2:    group = mod[19:15];
            3'd3:    group = mod[14:10];
            3'd4:    group = mod[9:5];
            default: group = mod[4:0];
        endcase
    end

    // Result character for the emitting step.
    always_comb
    begin
        out_next       = out_reg;
        out_next.last  = 1'b0;
        out_next.error = 1'b0;
        case (ctrl.emit)
            E_ECHO:   out_next.out_char = item_reg.prefix_char;
            E_SEP:    out_next.out_char = SEP_CHAR;
            E_LETTER: out_next.out_char = letter(item_reg.data_symbol);
            E_CHECK:
            begin
                out_next.out_char = letter(group);
                out_next.last     = (walk_reg == WALK_W'(CHK_LAST));
            end
            E_ERROR:
            begin
                out_next.out_char = NULL_CHAR;
                out_next.error    = 1'b1;
            end
            default:  out_next.out_char = NULL_CHAR;
        endcase
    end

    // The output slot frees up when the receiver takes its result.
    assign out_free = !out_valid_reg || !chr_stall;

    always_comb
    begin
        if (emit_go)
            out_valid_next = 1'b1;
        else if (!chr_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign chr_valid = out_valid_reg;
    assign chr_data  = out_reg;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= ACC_RESET;
            count_reg     <= '0;
            dp_reg        <= 1'b0;
            walk_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            count_reg     <= count_next;
            dp_reg        <= dp_next;
            walk_reg      <= walk_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: request copy and result.
    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= item;
        if (emit_go)
            out_reg <= out_next;
    end

    // Low-part store: one write, one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (go && ctrl.store_wr)
            low_part_mem[count_reg[ADDR_W-1:0]] <= item_reg.prefix_char[4:0];
        rd_data_reg <= low_part_mem[rd_addr];
    end

endmodule

[rtl/bech32_checksum_encoder.sv]
// ----------------------------------------------------------------------------
// bech32_checksum_encoder: streaming bech32 string encoder.
// Requests enter on sym_valid/sym_stall/sym_data: prefix characters, data
// symbols, then a finish request. Encoded ASCII leaves one character per
// result on chr_valid/chr_stall/chr_data, with last on the final checksum
// letter and error on a rejected request.
// A prefix character or data symbol is accepted at the idle step, then its
// own ROM step loads its result into the output register. The first data
// symbol (or a finish with no data) closes the prefix: it adds a close step,
// a separator step and one walk step per stored prefix character, as the ROM
// walks the low-part memory one read port entry per step. Finish runs six
// polymod folds, a setup step, six emitted letters, a clear and the idle step.
// A new request is taken only when the sequencer is back at its idle step.
// Reset returns the accumulator, prefix count and phase to an empty string.
// While the receiver stalls, the held result stays and the sequencer waits
// at its next emitting step.
// ----------------------------------------------------------------------------
module bech32_checksum_encoder #(
    parameter int MAX_PREFIX = bce_pkg::MAX_PREFIX_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sym_valid,
    output logic                sym_stall,
    input  bce_pkg::in_item_t   sym_data,
    output logic                chr_valid,
    input  logic                chr_stall,
    output bce_pkg::out_item_t  chr_data
);
    import bce_pkg::*;

    ctrl_t   ctrl;
    status_t status;
    logic    go;
    logic    at_idle;
    logic    out_free;
    logic    accept;

    // Requests are taken only at the idle step.
    assign sym_stall = !at_idle;
    assign accept    = sym_valid && at_idle;

    // Microcode sequencer.
    bce_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .sym_valid (sym_valid),
        .sym_op    (sym_data.op),
        .status    (status),
        .out_free  (out_free),
        .ctrl      (ctrl),
        .go        (go),
        .at_idle   (at_idle)
    );

    // Datapath.
    bce_dp #(
        .MAX_PREFIX (MAX_PREFIX)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .go        (go),
        .accept    (accept),
        .item      (sym_data),
        .chr_stall (chr_stall),
        .status    (status),
        .out_free  (out_free),
        .chr_valid (chr_valid),
        .chr_data  (chr_data)
    );

endmodule
